// File: rtl/uesc_pkg.sv
// Shared types and constants for the backslash-u escape decoder.
// No dependencies; used by every RTL module of the decoder.
package uesc_pkg;

  localparam int BYTE_W = 8;
  localparam int UNIT_W = 16;

  // Fixed character and code-unit values
  localparam logic [UNIT_W-1:0] REPL_UNIT  = 16'hFFFD;
  localparam logic [BYTE_W-1:0] CH_BSLASH  = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_LOWER_U = 8'h75;
  localparam logic [BYTE_W-1:0] CH_UPPER_U = 8'h55;
  localparam logic [BYTE_W-1:0] CH_LOWER_N = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_LOWER_R = 8'h72;
  localparam logic [BYTE_W-1:0] CH_LOWER_T = 8'h74;
  localparam logic [3:0]        HEX_ALPHA_BASE = 4'hA;

  // Units produced by one byte: count (0..2) and up to two code units
  typedef struct packed {
    logic [1:0]        cnt;
    logic [UNIT_W-1:0] unit0;
    logic [UNIT_W-1:0] unit1;
  } dec_res_t;

endpackage

// File: rtl/uesc_decode.sv
// Escape decoder: escape state and hex accumulator, one byte per step.
// Depends on uesc_pkg; produces up to two code units per byte.
module uesc_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [uesc_pkg::BYTE_W-1:0] byte_in,
  input  logic                        take,
  output uesc_pkg::dec_res_t          res
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ESC  = 3'd1,
    PH_HEX1 = 3'd2,
    PH_HEX2 = 3'd3,
    PH_HEX3 = 3'd4,
    PH_HEX4 = 3'd5
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic [uesc_pkg::UNIT_W-1:0] hex_r, hex_nxt;
  logic [uesc_pkg::UNIT_W-1:0] plain;
  logic [uesc_pkg::UNIT_W-1:0] hex_shift;
  logic                        is_hex;
  logic [3:0]                  digit;

  // Plain byte, high bytes become the replacement unit
  assign plain = byte_in[uesc_pkg::BYTE_W-1] ? uesc_pkg::REPL_UNIT
                                              : {8'h00, byte_in};

  // Hex digit recognition, either case
  always_comb begin
    is_hex = 1'b0;
    digit  = 4'h0;
    if (byte_in >= 8'h30 && byte_in <= 8'h39) begin
      is_hex = 1'b1;
      digit  = 4'(byte_in - 8'h30);
    end else if (byte_in >= 8'h61 && byte_in <= 8'h66) begin
      is_hex = 1'b1;
      digit  = 4'(byte_in - 8'h61) + uesc_pkg::HEX_ALPHA_BASE;
    end else if (byte_in >= 8'h41 && byte_in <= 8'h46) begin
      is_hex = 1'b1;
      digit  = 4'(byte_in - 8'h41) + uesc_pkg::HEX_ALPHA_BASE;
    end
  end

  assign hex_shift = {hex_r[uesc_pkg::UNIT_W-5:0], digit};

  // Next state and emitted units
  always_comb begin
    phase_nxt = phase_r;
    hex_nxt   = hex_r;
    res.cnt   = 2'd1;
    res.unit0 = plain;
    res.unit1 = plain;
    unique case (phase_r)
      PH_ESC: begin
        phase_nxt = PH_IDLE;
        if (byte_in == uesc_pkg::CH_LOWER_U || byte_in == uesc_pkg::CH_UPPER_U) begin
          hex_nxt   = '0;
          phase_nxt = PH_HEX1;
          res.cnt   = 2'd0;
        end else if (byte_in == uesc_pkg::CH_LOWER_N || byte_in == uesc_pkg::CH_LOWER_R ||
                     byte_in == uesc_pkg::CH_LOWER_T) begin
          res.cnt   = 2'd2;
          res.unit0 = {8'h00, uesc_pkg::CH_BSLASH};
        end
      end
      PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
        if (is_hex) begin
          hex_nxt = hex_shift;
          if (phase_r == PH_HEX4) begin
            phase_nxt = PH_IDLE;
            res.unit0 = hex_shift;
          end else begin
            phase_nxt = phase_t'(phase_r + 3'd1);
            res.cnt   = 2'd0;
          end
        end else begin
          // partial value, then the offending byte
          phase_nxt = PH_IDLE;
          res.cnt   = 2'd2;
          res.unit0 = hex_r;
        end
      end
      default: begin
        if (byte_in == uesc_pkg::CH_BSLASH) begin
          phase_nxt = PH_ESC;
          res.cnt   = 2'd0;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hex_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      hex_r   <= hex_nxt;
    end
  end

endmodule

// File: rtl/uesc_outq.sv
// Two-entry result queue that serializes code units onto the output stream.
// Depends on uesc_pkg; takes a whole pair per push, emits one unit per cycle while out_tready is high.
module uesc_outq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  uesc_pkg::dec_res_t          res,
  input  logic                        push,
  output logic                        room,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [uesc_pkg::UNIT_W-1:0] out_tdata,   // [15:0] code_unit
  output logic                        out_tlast    // last_unit
);

  logic [uesc_pkg::UNIT_W-1:0] q_unit_r [2];
  logic [uesc_pkg::UNIT_W-1:0] q_unit_nxt [2];
  logic [1:0]                  q_last_r, q_last_nxt;
  logic [1:0]                  q_cnt_r, q_cnt_nxt;
  logic [1:0]                  cnt_pop;
  logic                        pop;

  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_tdata  = q_unit_r[0];
  assign out_tlast  = q_last_r[0];
  assign pop        = out_tvalid && out_tready;
  assign cnt_pop    = q_cnt_r - {1'b0, pop};
  assign room       = ({1'b0, cnt_pop} + {1'b0, res.cnt}) <= 3'd2;

  // Shift on pop, then append the new pair behind what is left
  always_comb begin
    q_unit_nxt = q_unit_r;
    q_last_nxt = q_last_r;
    if (pop) begin
      q_unit_nxt[0] = q_unit_r[1];
      q_last_nxt[0] = q_last_r[1];
    end
    q_cnt_nxt = cnt_pop;
    if (push && res.cnt != 2'd0) begin
      q_cnt_nxt = cnt_pop + res.cnt;
      if (cnt_pop == 2'd0) begin
        q_unit_nxt[0] = res.unit0;
        q_last_nxt[0] = (res.cnt == 2'd1);
        q_unit_nxt[1] = res.unit1;
        q_last_nxt[1] = 1'b1;
      end else begin
        q_unit_nxt[1] = res.unit0;
        q_last_nxt[1] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
    q_unit_r <= q_unit_nxt;
    q_last_r <= q_last_nxt;
  end

endmodule

// File: rtl/unicode_escape_decoder_top.sv
// An accepted byte is held in the input register until the output queue has room
// for its code units. Throughput: one byte per cycle for bytes with at most one
// unit while out_tready is high; a byte with two units fills the output queue, so
// the sustained worst case is set by the one-unit-per-cycle output port.
// Reset (rst_n low, synchronous) empties the input register and output queue
// and returns the decoder to idle with a cleared hex accumulator.
module unicode_escape_decoder_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [uesc_pkg::BYTE_W-1:0] in_tdata,    // [7:0] in_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [uesc_pkg::UNIT_W-1:0] out_tdata,   // [15:0] code_unit
  output logic                        out_tlast    // last_unit
);

  logic                        s1_valid_r;
  logic [uesc_pkg::BYTE_W-1:0] s1_byte_r;
  logic                        take;
  logic                        room;
  uesc_pkg::dec_res_t          res;

  // Input register; refills as soon as its byte moves on
  assign take      = s1_valid_r && room;
  assign in_tready = !s1_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  uesc_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_in (s1_byte_r),
    .take    (take),
    .res     (res)
  );

  uesc_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .push       (take),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: rtl/uesc_checker.sv
// Port-level checks for the escape decoder, bound to the top level.
// Depends on uesc_pkg for widths; sees only the top-level ports.
module uesc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [uesc_pkg::UNIT_W-1:0] out_tdata,
  input logic                        out_tlast
);

  // Reset empties the output queue
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stalled unit holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

  // The second unit of a pair is queued with the first
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("second unit of pair missing");

  // With the queue empty the input side never stalls
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output queue empty");

endmodule

bind unicode_escape_decoder_top uesc_checker u_uesc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
